// File: rtl/session_table_with_aging_assert.svh
// Assertion macros for the session table.
`ifndef SESSION_TABLE_WITH_AGING_ASSERT_SVH
`define SESSION_TABLE_WITH_AGING_ASSERT_SVH
`ifndef ASSERT_OFF
`define STAI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STAI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STAI_ASSERT(lbl, clk, rst_n, prop, msg)
`define STAI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/stai_pkg.sv
package stai_pkg;

  localparam int TableEntriesDef = 128;
  localparam int KeyBytes = 16;
  localparam logic [15:0] TimeoutRst = 16'd30;

  function automatic logic [63:0] key_mask(input int nbytes);
    logic [63:0] m;
    if (nbytes <= 0) begin
      m = '0;
    end else if (nbytes >= 8) begin
      m = '1;
    end else begin
      m = ~({64{1'b1}} >> (8 * nbytes));
    end
    return m;
  endfunction

  localparam logic [63:0] KeyMaskHi = key_mask(KeyBytes);
  localparam logic [63:0] KeyMaskLo = key_mask(KeyBytes - 8);

  typedef enum logic [1:0] {
    OP_HEARTBEAT = 2'd0,
    OP_LOOKUP    = 2'd1,
    OP_QUERY     = 2'd2,
    OP_SWEEP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_RESP
  } eng_state_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] key_u;
    logic [63:0] key_l;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] seq;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        active;
    logic        roamed;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  expired;
  } result_t;

  typedef struct packed {
    logic [63:0] key_u;
    logic [63:0] key_l;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] stamp;
    logic [31:0] seq;
    logic        valid;
  } entry_t;

endpackage

// File: rtl/stai_front.sv
module stai_front
  import stai_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_upper_i,
  input  logic [63:0] key_lower_i,
  input  logic [31:0] addr_ip_i,
  input  logic [15:0] addr_port_i,
  input  logic [31:0] seq_num_i,
  input  logic [31:0] now_time_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_pop_i
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;
  item_t      in_item;

  // key bytes past the identifier length are dropped here
  always_comb begin
    in_item.op    = op_e'(operation_i);
    in_item.key_u = key_upper_i & KeyMaskHi;
    in_item.key_l = key_lower_i & KeyMaskLo;
    in_item.ip    = addr_ip_i;
    in_item.port  = addr_port_i;
    in_item.seq   = seq_num_i;
    in_item.now   = now_time_i;
  end

  assign full         = (count_q == 2'd2);
  assign do_push      = push && !full;
  assign item_valid_o = (count_q != 2'd0);
  assign do_pop       = item_pop_i && item_valid_o;
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/stai_engine.sv
`include "session_table_with_aging_assert.svh"
module stai_engine
  import stai_pkg::*;
#(
  parameter int TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] timeout_i,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  output logic        res_push_o,
  output result_t     res_o,
  input  logic        res_full_i
);

  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int CW1  = CntW + 1;

  entry_t     mem [TableEntries];
  entry_t     rd_row_q;
  logic [IdxW-1:0] rd_addr, wr_addr;
  entry_t     wr_row;
  logic       wr_en;

  eng_state_e state_q, state_d;
  item_t      item_q, item_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [7:0] exp_q, exp_d;
  result_t    res_q, res_d;

  logic            entry_ok, last, hit, key_eq;
  logic signed [32:0] age;
  logic            age_lt, age_gt;
  logic [CW1-1:0]  idx_ext, fill_ext;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_row_q <= mem[rd_addr];
  end

  assign idx_ext  = CW1'(idx_q);
  assign fill_ext = CW1'(fill_q);
  assign entry_ok = idx_ext < fill_ext;
  assign last     = (idx_ext + CW1'(1)) >= fill_ext;
  assign key_eq   = (rd_row_q.key_u == item_q.key_u) && (rd_row_q.key_l == item_q.key_l);
  assign hit      = entry_ok && key_eq;

  // signed age: a stamp in the future counts as fresh
  assign age    = $signed({1'b0, item_q.now}) - $signed({1'b0, rd_row_q.stamp});
  assign age_lt = age < $signed({17'd0, timeout_i});
  assign age_gt = age > $signed({17'd0, timeout_i});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ENG_IDLE: if (item_valid_i) state_d = ENG_SCAN;
      ENG_SCAN: begin
        if (!entry_ok || last || (hit && item_q.op != OP_SWEEP)) state_d = ENG_RESP;
      end
      ENG_RESP: if (!res_full_i) state_d = ENG_IDLE;
      default:  state_d = ENG_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    item_d     = item_q;
    idx_d      = idx_q;
    fill_d     = fill_q;
    exp_d      = exp_q;
    res_d      = res_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_row     = rd_row_q;
    case (state_q)
      ENG_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          idx_d      = '0;
          exp_d      = 8'd0;
        end
      end
      ENG_SCAN: begin
        rd_addr = idx_q + IdxW'(1);
        idx_d   = idx_q + IdxW'(1);
        res_d   = '{status: ST_OK, active: 1'b0, roamed: 1'b0,
                    ip: 32'd0, port: 16'd0, expired: 8'd0};
        case (item_q.op)
          OP_SWEEP: begin
            if (entry_ok && rd_row_q.valid && age_gt) begin
              wr_en        = 1'b1;
              wr_row.valid = 1'b0;
              if (exp_q != 8'hFF) exp_d = exp_q + 8'd1;
            end
            res_d.expired = exp_d;
          end
          OP_HEARTBEAT: begin
            wr_row.ip    = item_q.ip;
            wr_row.port  = item_q.port;
            wr_row.stamp = item_q.now;
            wr_row.seq   = item_q.seq;
            wr_row.valid = 1'b1;
            if (hit) begin
              wr_en        = 1'b1;
              res_d.roamed = (rd_row_q.ip != item_q.ip) || (rd_row_q.port != item_q.port);
            end else if (!entry_ok || last) begin
              if (fill_q >= CntW'(TableEntries)) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = IdxW'(fill_q);
                wr_row.key_u = item_q.key_u;
                wr_row.key_l = item_q.key_l;
                fill_d       = fill_q + CntW'(1);
              end
            end
          end
          OP_LOOKUP: begin
            if (hit && rd_row_q.valid) begin
              res_d.ip   = rd_row_q.ip;
              res_d.port = rd_row_q.port;
            end else begin
              res_d.status = ST_MISSING;
            end
          end
          OP_QUERY: begin
            if (hit && rd_row_q.valid && age_lt) begin
              res_d.active = 1'b1;
            end else begin
              res_d.status = ST_MISSING;
            end
          end
          default: ;
        endcase
      end
      ENG_RESP: res_push_o = !res_full_i;
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    exp_q  <= exp_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  `STAI_ASSERT_ALWAYS(a_fill_bound, clk_i, fill_q <= CntW'(TableEntries), "fill count overflow")
  `STAI_ASSERT(a_fill_step, clk_i, rst_ni, fill_q != $past(fill_q) |-> fill_q == $past(fill_q) + CntW'(1), "fill count jumped")
  `STAI_ASSERT(a_push_space, clk_i, rst_ni, res_push_o |-> !res_full_i, "result push into full queue")
  `STAI_ASSERT(a_pop_idle, clk_i, rst_ni, item_pop_o |=> state_q == ENG_SCAN, "item taken outside idle")

endmodule

// File: rtl/stai_outq.sv
`include "session_table_with_aging_assert.svh"
module stai_outq
  import stai_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_push_i,
  input  result_t res_i,
  output logic    res_full_o,
  output logic    empty,
  input  logic    pop,
  output result_t res_o
);

  result_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign res_full_o = (count_q == 2'd2);
  assign empty      = (count_q == 2'd0);
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;
  assign res_o      = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `STAI_ASSERT_ALWAYS(a_count_bound, clk_i, count_q <= 2'd2, "result queue count overflow")
  `STAI_ASSERT(a_ptr_gap, clk_i, rst_ni, (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q), "pointer mismatch")
  `STAI_ASSERT(a_full_hold, clk_i, rst_ni, res_full_o && !pop |=> res_full_o, "full queue lost entry")

endmodule

// File: rtl/session_table_with_aging.sv
// Session table: one result per item. Search and sweep read one table row per cycle
// from a memory with one read and one write port; an item reads n rows (n = fill count,
// at least 1, fewer on an early key match). The engine takes the next item only after
// the previous result has been pushed; two-entry queues on input and result side
// decouple both neighbors. Reset (async, active low) clears fill count, queues and
// state; timeout = 30.
module session_table_with_aging
  import stai_pkg::*;
#(
  parameter int TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_upper_i,
  input  logic [63:0] key_lower_i,
  input  logic [31:0] addr_ip_i,
  input  logic [15:0] addr_port_i,
  input  logic [31:0] seq_num_i,
  input  logic [31:0] now_time_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic        is_active_o,
  output logic        roamed_o,
  output logic [31:0] result_ip_o,
  output logic [15:0] result_port_o,
  output logic [7:0]  expired_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] timeout_q;
  logic        item_valid, item_pop, res_push, res_full;
  item_t       item;
  result_t     res_in, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  stai_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .operation_i, .key_upper_i, .key_lower_i, .addr_ip_i, .addr_port_i,
    .seq_num_i, .now_time_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  stai_engine #(.TableEntries(TableEntries)) u_engine (
    .clk_i, .rst_ni,
    .timeout_i    (timeout_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  stai_outq u_outq (
    .clk_i, .rst_ni,
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty, .pop,
    .res_o      (res_out)
  );

  assign status_o        = res_out.status;
  assign is_active_o     = res_out.active;
  assign roamed_o        = res_out.roamed;
  assign result_ip_o     = res_out.ip;
  assign result_port_o   = res_out.port;
  assign expired_count_o = res_out.expired;

endmodule

// File: verif/session_table_with_aging_checker.sv
`timescale 1ns / 100ps

module session_table_with_aging_checker
  import stai_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_upper_i,
  input  logic [63:0] key_lower_i,
  input  logic [31:0] addr_ip_i,
  input  logic [15:0] addr_port_i,
  input  logic [31:0] seq_num_i,
  input  logic [31:0] now_time_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  status_o,
  input  logic        is_active_o,
  input  logic        roamed_o,
  input  logic [31:0] result_ip_o,
  input  logic [15:0] result_port_o,
  input  logic [7:0]  expired_count_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  entry_t      sessions[TableEntriesDef];
  int          sessions_used;
  logic [15:0] timeout_secs;
  result_t     expected_q[$];

  assign pending_o = expected_q.size();

  function automatic int find_session(logic [63:0] ku, logic [63:0] kl);
    for (int i = 0; i < sessions_used; i++)
      if (sessions[i].key_u == ku && sessions[i].key_l == kl) return i;
    return -1;
  endfunction

  // age is a signed difference; a stamp in the future counts as fresh
  function automatic longint age_at(int idx, logic [31:0] now);
    return longint'({32'd0, now}) - longint'({32'd0, sessions[idx].stamp});
  endfunction

  function automatic result_t apply_item(item_t it);
    result_t r;
    int idx;
    logic [63:0] ku;
    logic [63:0] kl;
    r = '0;
    r.status = ST_OK;
    ku = it.key_u & KeyMaskHi;
    kl = it.key_l & KeyMaskLo;
    idx = find_session(ku, kl);
    case (it.op)
      OP_HEARTBEAT: begin
        if (idx >= 0) begin
          r.roamed = sessions[idx].ip != it.ip || sessions[idx].port != it.port;
        end else if (sessions_used >= TableEntriesDef) begin
          r.status = ST_FULL;
        end else begin
          idx = sessions_used++;
          sessions[idx].key_u = ku;
          sessions[idx].key_l = kl;
        end
        if (idx >= 0) begin
          sessions[idx].ip = it.ip;
          sessions[idx].port = it.port;
          sessions[idx].stamp = it.now;
          sessions[idx].seq = it.seq;
          sessions[idx].valid = 1'b1;
        end
      end
      OP_LOOKUP: begin
        r.status = ST_MISSING;
        for (int i = 0; i < sessions_used; i++) begin
          if (sessions[i].key_u == ku && sessions[i].key_l == kl && sessions[i].valid) begin
            r.status = ST_OK;
            r.ip = sessions[i].ip;
            r.port = sessions[i].port;
            break;
          end
        end
      end
      OP_QUERY: begin
        r.active = idx >= 0 && sessions[idx].valid &&
                   age_at(idx, it.now) < longint'(timeout_secs);
        r.status = r.active ? ST_OK : ST_MISSING;
      end
      default: begin
        for (int i = 0; i < sessions_used; i++) begin
          if (sessions[i].valid && age_at(i, it.now) > longint'(timeout_secs)) begin
            sessions[i].valid = 1'b0;
            if (r.expired != 8'hFF) r.expired++;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t got;
    result_t want;
    if (!rst_ni) begin
      sessions_used = 0;
      timeout_secs = TimeoutRst;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) timeout_secs = cfg_data_i;
      if (pop && !empty) begin
        got.status = status_e'(status_o);
        got.active = is_active_o;
        got.roamed = roamed_o;
        got.ip = result_ip_o;
        got.port = result_port_o;
        got.expired = expired_count_o;
        if (expected_q.size() == 0) begin
          $error("result with no pending transaction");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count_o++;
          end
          if (got.active !== want.active) begin
            $error("is_active: expected %0d, got %0d", want.active, got.active);
            fail_count_o++;
          end
          if (got.roamed !== want.roamed) begin
            $error("roamed: expected %0d, got %0d", want.roamed, got.roamed);
            fail_count_o++;
          end
          if (got.ip !== want.ip) begin
            $error("result_ip: expected %h, got %h", want.ip, got.ip);
            fail_count_o++;
          end
          if (got.port !== want.port) begin
            $error("result_port: expected %h, got %h", want.port, got.port);
            fail_count_o++;
          end
          if (got.expired !== want.expired) begin
            $error("expired_count: expected %0d, got %0d", want.expired, got.expired);
            fail_count_o++;
          end
        end
      end
      if (push && !full) begin
        it.op = op_e'(operation_i);
        it.key_u = key_upper_i;
        it.key_l = key_lower_i;
        it.ip = addr_ip_i;
        it.port = addr_port_i;
        it.seq = seq_num_i;
        it.now = now_time_i;
        expected_q.push_back(apply_item(it));
      end
    end
  end

endmodule

// File: verif/session_table_with_aging_tb.sv
`timescale 1ns / 100ps

module session_table_with_aging_tb
  import stai_pkg::*;
();

  localparam int StallLimit = 20000;
  localparam int KeyPool = 160;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  operation_i;
  logic [63:0] key_upper_i;
  logic [63:0] key_lower_i;
  logic [31:0] addr_ip_i;
  logic [15:0] addr_port_i;
  logic [31:0] seq_num_i;
  logic [31:0] now_time_i;
  logic        empty;
  logic        pop;
  logic [1:0]  status_o;
  logic        is_active_o;
  logic        roamed_o;
  logic [31:0] result_ip_o;
  logic [15:0] result_port_o;
  logic [7:0]  expired_count_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          no_idle;
  bit          timed_out;
  logic [63:0] key_pool_u[KeyPool];
  logic [63:0] key_pool_l[KeyPool];
  logic [31:0] clock_now;

  session_table_with_aging uut (.*);

  session_table_with_aging_checker u_checker (
    .fail_count_o(fail_count), .pending_o(pending), .*
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side: random pop stalls in bursts
  initial begin
    int gap;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("** session_table_with_aging: FAILED **");
      $finish;
    end
  end

  task automatic send_item(op_e op, logic [63:0] ku, logic [63:0] kl,
                           logic [31:0] ip, logic [15:0] port,
                           logic [31:0] seq, logic [31:0] now);
    push <= 1'b1;
    operation_i <= op;
    key_upper_i <= ku;
    key_lower_i <= kl;
    addr_ip_i <= ip;
    addr_port_i <= port;
    seq_num_i <= seq;
    now_time_i <= now;
    do @(posedge clk_i); while (full);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    // a wait on the clock lets the checker count the last transaction
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item(int pool_size);
    int k;
    int pick;
    logic [63:0] ku;
    logic [63:0] kl;
    logic [31:0] now;
    k = $urandom_range(0, pool_size - 1);
    ku = key_pool_u[k];
    kl = key_pool_l[k];
    if ($urandom_range(0, 15) == 0) begin
      ku = {$urandom, $urandom};
      kl = {$urandom, $urandom};
    end
    clock_now += $urandom_range(0, 12);
    now = clock_now;
    if ($urandom_range(0, 19) == 0) now = {$urandom};
    else if ($urandom_range(0, 9) == 0) now = clock_now - $urandom_range(0, 40);
    pick = $urandom_range(0, 9);
    send_item(pick < 4 ? OP_HEARTBEAT : pick < 6 ? OP_LOOKUP : pick < 9 ? OP_QUERY : OP_SWEEP,
              ku, kl,
              $urandom_range(0, 3) == 0 ? $urandom : 32'h0A00_0000 | $urandom_range(0, 3),
              $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'(4000 + $urandom_range(0, 2)),
              $urandom, now);
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    operation_i = OP_HEARTBEAT;
    key_upper_i = '0;
    key_lower_i = '0;
    addr_ip_i = '0;
    addr_port_i = '0;
    seq_num_i = '0;
    now_time_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    no_idle = 1'b0;
    timed_out = 1'b0;
    clock_now = 32'd1000;
    for (int i = 0; i < KeyPool; i++) begin
      key_pool_u[i] = {$urandom, $urandom};
      key_pool_l[i] = {$urandom, $urandom};
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, all ops, roam, future stamp, boundary ages
    send_item(OP_LOOKUP, '0, '0, '0, '0, '0, '0);
    send_item(OP_QUERY, '1, '1, '0, '0, '0, '1);
    send_item(OP_HEARTBEAT, '0, '0, '0, '0, '0, 32'd100);
    send_item(OP_HEARTBEAT, '1, '1, '1, '1, '1, '1);
    send_item(OP_HEARTBEAT, '0, '0, '0, '0, 32'd7, 32'd100);
    send_item(OP_HEARTBEAT, '0, '0, 32'h1, '0, 32'd8, 32'd100);
    send_item(OP_HEARTBEAT, '0, '0, 32'h1, 16'h1, 32'd9, 32'd100);
    send_item(OP_LOOKUP, '0, '0, '0, '0, '0, '0);
    send_item(OP_LOOKUP, '1, '1, '0, '0, '0, '0);
    send_item(OP_QUERY, '0, '0, '0, '0, '0, 32'd129);
    send_item(OP_QUERY, '0, '0, '0, '0, '0, 32'd130);
    send_item(OP_QUERY, '0, '0, '0, '0, '0, 32'd50);
    send_item(OP_SWEEP, '0, '0, '0, '0, '0, 32'd130);
    send_item(OP_SWEEP, '0, '0, '0, '0, '0, 32'd131);
    send_item(OP_QUERY, '0, '0, '0, '0, '0, 32'd100);
    send_item(OP_LOOKUP, '0, '0, '0, '0, '0, '0);
    send_item(OP_SWEEP, '0, '0, '0, '0, '0, '1);

    write_timeout(16'd1);
    send_item(OP_HEARTBEAT, 64'h8000_0000_0000_0001, 64'h1, 32'h5, 16'h5, '0, 32'd10);
    send_item(OP_QUERY, 64'h8000_0000_0000_0001, 64'h1, '0, '0, '0, 32'd10);
    send_item(OP_QUERY, 64'h8000_0000_0000_0001, 64'h1, '0, '0, '0, 32'd11);
    send_item(OP_SWEEP, '0, '0, '0, '0, '0, 32'd12);
    write_timeout(16'hFFFF);
    send_item(OP_SWEEP, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
    write_timeout(16'd30);

    // random phases with varying timeouts; pool larger than the table fills it
    for (int ph = 0; ph < 6; ph++) begin
      for (int n = 0; n < 230; n++) begin
        if (ph == 5 && n == 150) no_idle = 1'b1;
        random_item(ph < 2 ? 24 : KeyPool);
      end
      if (ph == 2) begin
        // flood unknown keys to hit the full-table path
        for (int n = 0; n < 40; n++)
          send_item(OP_HEARTBEAT, {$urandom, $urandom}, {$urandom, $urandom},
                    $urandom, 16'($urandom), $urandom, clock_now);
      end
      if (ph < 5) begin
        case (ph)
          0: write_timeout(16'd5);
          1: write_timeout(16'd1);
          2: write_timeout(16'd65535);
          3: write_timeout(16'($urandom_range(1, 100)));
          default: write_timeout(16'd20);
        endcase
      end
    end

    drain();
    if (fail_count == 0)
      $display("** session_table_with_aging: PASSED **");
    else
      $display("** session_table_with_aging: FAILED **");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/stai_pkg.sv
rtl/stai_front.sv
rtl/stai_engine.sv
rtl/stai_outq.sv
rtl/session_table_with_aging.sv
verif/session_table_with_aging_checker.sv
verif/session_table_with_aging_tb.sv
